// ----- src/lpad_pkg.sv -----
package lpad_pkg;

    // Frame layout
    localparam int HEADER_BYTES = 4;
    localparam int HDR_IDX_W    = $clog2(HEADER_BYTES);
    localparam int WORD_W       = 8 * HEADER_BYTES;
    localparam int LEN_W        = WORD_W - 1;

    // Smallest legal name length: one visible byte plus the terminator
    localparam int MIN_NAME_LEN = 2;

    // Adler-32
    localparam logic [15:0] ADLER_MOD = 16'd65521;

    // Configuration registers
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 31;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_FRAME_LEN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_LEN = 1'd1;
    localparam logic [CFG_W-1:0] MIN_FRAME_LEN_RST = 31'd10;
    localparam logic [CFG_W-1:0] MAX_FRAME_LEN_RST = 31'd67108864;

    // Result kinds
    localparam logic [1:0] KIND_NAME    = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    // Frame status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_LEN  = 2'd1;
    localparam logic [1:0] ST_BAD_NAME = 2'd2;
    localparam logic [1:0] ST_BAD_SUM  = 2'd3;

    // Command queue between parser and executor
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    typedef enum logic [2:0] {
        OP_SUM,       // header or terminator byte: checksum only
        OP_NAME,      // visible name byte
        OP_PAY,       // payload byte
        OP_CHK,       // check byte, not the last
        OP_CHK_LAST,  // last check byte: compare and report
        OP_ERR_LEN,   // frame length out of range
        OP_ERR_NAME   // name length out of range
    } t_op;

    typedef struct packed {
        logic [7:0] data;
        t_op        op;
    } t_cmd;

endpackage

// ----- src/lpad_in_if.sv -----
interface lpad_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

// ----- src/lpad_out_if.sv -----
interface lpad_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] out_kind;
    logic [1:0] status;

    modport source (output valid, output out_byte, output out_kind, output status,
                    input ready);
    modport sink   (input valid, input out_byte, input out_kind, input status,
                    output ready);
endinterface

// ----- src/length_prefixed_adler_deframer.sv -----
// Deframer for length-prefixed frames closed by an Adler-32 check word. It takes one
// stream byte per cycle while the command queue is not full and puts out name bytes
// (terminator dropped), payload bytes and one status result per frame; a frame is good
// only if its status is ok. Any error (frame length outside min_frame_len..max_frame_len,
// name length outside 2..L-8, checksum mismatch) reports its status and then swallows
// every byte until reset. Throughput is one byte per cycle while the queue has room: the
// parser classifies each byte combinationally and the executor runs one Adler-32 update
// per summed byte. A four-entry command queue sits between them, so the parser keeps
// accepting bytes while the output is stalled until four commands are queued. A result
// passes through the command queue and the executor's output register before it is offered.
// Write min_frame_len and max_frame_len only while no frame is in progress.
module length_prefixed_adler_deframer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lpad_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [lpad_pkg::CFG_W-1:0]     i_cfg_data,
    lpad_in_if.sink                        i_in_ch,
    lpad_out_if.source                     o_out_ch
);
    import lpad_pkg::*;

    logic w_push, w_full, w_pop, w_empty;
    t_cmd w_cmd_in, w_cmd_out;

    // parser, command queue, executor
    lpad_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_ch    (i_in_ch),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_cmd      (w_cmd_in)
    );

    lpad_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_cmd   (w_cmd_out)
    );

    lpad_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (w_empty),
        .i_cmd    (w_cmd_out),
        .o_pop    (w_pop),
        .o_out_ch (o_out_ch)
    );

endmodule

// ----- src/lpad_front.sv -----
module lpad_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [lpad_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [lpad_pkg::CFG_W-1:0]     i_cfg_data,
    lpad_in_if.sink                  i_in_ch,
    input  logic                     i_full,
    output logic                     o_push,
    output lpad_pkg::t_cmd           o_cmd
);
    import lpad_pkg::*;

    typedef enum logic [2:0] {
        PH_LEN,
        PH_NLEN,
        PH_NAME,
        PH_PAY,
        PH_CHK,
        PH_HALT
    } t_phase;

    t_phase             r_ph, n_ph;
    logic [LEN_W-1:0]   r_cnt, n_cnt;
    logic [WORD_W-1:0]  r_sh;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [LEN_W-1:0]   r_name_last, n_name_last;
    logic [LEN_W-1:0]   r_frame_last, n_frame_last;
    logic [CFG_W-1:0]   r_min, r_max;

    logic [7:0]         w_b;
    logic [WORD_W-1:0]  w_word;
    logic               w_acc;
    logic               w_hdr_last;
    logic               w_bad_len;
    logic               w_bad_name;
    logic [WORD_W-1:0]  w_n_plus8;
    logic [WORD_W-1:0]  w_n_plus7;
    t_op                w_op;

    assign w_b     = i_in_ch.in_byte;
    assign w_word  = {w_b, r_sh[WORD_W-1:8]};
    assign w_acc   = i_in_ch.valid && i_in_ch.ready;
    assign i_in_ch.ready = (r_ph == PH_HALT) || !i_full;

    assign w_hdr_last = (r_cnt[HDR_IDX_W-1:0] == HDR_IDX_W'(HEADER_BYTES - 1));

    // length checks on the completed little-endian word
    assign w_bad_len = w_word[WORD_W-1]
                    || (w_word[LEN_W-1:0] < r_min)
                    || (w_word[LEN_W-1:0] > r_max);
    assign w_n_plus8 = {1'b0, w_word[LEN_W-1:0]} + WORD_W'(2 * HEADER_BYTES);
    assign w_n_plus7 = {1'b0, w_word[LEN_W-1:0]} + WORD_W'(2 * HEADER_BYTES - 1);
    assign w_bad_name = w_word[WORD_W-1]
                     || (w_word[LEN_W-1:0] < LEN_W'(MIN_NAME_LEN))
                     || (w_n_plus8 > {1'b0, r_len});

    // byte classification and phase sequencing
    always_comb begin
        n_ph         = r_ph;
        n_cnt        = r_cnt + LEN_W'(1);
        n_len        = r_len;
        n_name_last  = r_name_last;
        n_frame_last = r_frame_last;
        w_op         = OP_SUM;
        case (r_ph)
            PH_LEN: begin
                if (w_hdr_last) begin
                    if (w_bad_len) begin
                        w_op = OP_ERR_LEN;
                        n_ph = PH_HALT;
                    end else begin
                        n_len = w_word[LEN_W-1:0];
                        n_ph  = PH_NLEN;
                    end
                end
            end
            PH_NLEN: begin
                if (w_hdr_last) begin
                    if (w_bad_name) begin
                        w_op = OP_ERR_NAME;
                        n_ph = PH_HALT;
                    end else begin
                        n_name_last  = w_n_plus7[LEN_W-1:0];
                        n_frame_last = r_len - LEN_W'(1);
                        n_ph         = PH_NAME;
                    end
                end
            end
            PH_NAME: begin
                if (r_cnt == r_name_last) begin
                    // terminator: summed but not shown
                    if (r_cnt == r_frame_last) begin
                        n_ph  = PH_CHK;
                        n_cnt = '0;
                    end else begin
                        n_ph = PH_PAY;
                    end
                end else begin
                    w_op = OP_NAME;
                end
            end
            PH_PAY: begin
                w_op = OP_PAY;
                if (r_cnt == r_frame_last) begin
                    n_ph  = PH_CHK;
                    n_cnt = '0;
                end
            end
            PH_CHK: begin
                if (w_hdr_last) begin
                    w_op  = OP_CHK_LAST;
                    n_ph  = PH_LEN;
                    n_cnt = '0;
                end else begin
                    w_op = OP_CHK;
                end
            end
            PH_HALT: begin
                n_cnt = r_cnt;
            end
            default: begin
                n_ph = PH_HALT;
            end
        endcase
    end

    assign o_push     = w_acc && (r_ph != PH_HALT);
    assign o_cmd.data = w_b;
    assign o_cmd.op   = w_op;

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph  <= PH_LEN;
            r_cnt <= '0;
        end else if (w_acc) begin
            r_ph  <= n_ph;
            r_cnt <= n_cnt;
        end
    end

    // field assembly, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_sh         <= w_word;
            r_len        <= n_len;
            r_name_last  <= n_name_last;
            r_frame_last <= n_frame_last;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= MIN_FRAME_LEN_RST;
            r_max <= MAX_FRAME_LEN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MIN_FRAME_LEN: r_min <= i_cfg_data;
                CFG_MAX_FRAME_LEN: r_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// ----- src/lpad_fifo.sv -----
module lpad_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lpad_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output lpad_pkg::t_cmd o_cmd
);
    import lpad_pkg::*;

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              w_push, w_pop;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + QPTR_W'(1);
            if (w_pop)  r_rd <= r_rd + QPTR_W'(1);
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - QCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr] <= i_cmd;
    end

endmodule

// ----- src/lpad_back.sv -----
module lpad_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  lpad_pkg::t_cmd i_cmd,
    output logic           o_pop,
    lpad_out_if.source     o_out_ch
);
    import lpad_pkg::*;

    logic [15:0]       r_a, r_b;
    logic [WORD_W-1:0] r_rcv;
    logic              r_halt;
    logic              r_ov;
    logic [7:0]        r_obyte;
    logic [1:0]        r_okind;
    logic [1:0]        r_ost;

    logic [16:0]       w_a1, w_b1;
    logic [15:0]       w_a, w_b;
    logic [WORD_W-1:0] w_rcv;
    logic              w_emits;
    logic              w_free;
    logic              w_exec;

    // Adler-32 running sums, one conditional subtract each
    assign w_a1 = {1'b0, r_a} + {9'b0, i_cmd.data};
    assign w_a  = (w_a1 >= {1'b0, ADLER_MOD}) ? 16'(w_a1 - {1'b0, ADLER_MOD}) : w_a1[15:0];
    assign w_b1 = {1'b0, r_b} + {1'b0, w_a};
    assign w_b  = (w_b1 >= {1'b0, ADLER_MOD}) ? 16'(w_b1 - {1'b0, ADLER_MOD}) : w_b1[15:0];

    assign w_rcv = {i_cmd.data, r_rcv[WORD_W-1:8]};

    assign w_emits = (i_cmd.op == OP_NAME) || (i_cmd.op == OP_PAY)
                  || (i_cmd.op == OP_CHK_LAST) || (i_cmd.op == OP_ERR_LEN)
                  || (i_cmd.op == OP_ERR_NAME);
    assign w_free  = !r_ov || o_out_ch.ready;
    // after a halt the queue drains without effect
    assign o_pop   = !i_empty && (r_halt || !w_emits || w_free);
    assign w_exec  = o_pop && !r_halt;

    assign o_out_ch.valid    = r_ov;
    assign o_out_ch.out_byte = r_obyte;
    assign o_out_ch.out_kind = r_okind;
    assign o_out_ch.status   = r_ost;

    // control: sums, halt flag, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a    <= 16'd1;
            r_b    <= 16'd0;
            r_halt <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (w_exec && w_emits) begin
                r_ov <= 1'b1;
            end else if (o_out_ch.ready) begin
                r_ov <= 1'b0;
            end
            if (w_exec) begin
                case (i_cmd.op)
                    OP_SUM, OP_NAME, OP_PAY: begin
                        r_a <= w_a;
                        r_b <= w_b;
                    end
                    OP_CHK_LAST: begin
                        if (w_rcv != {r_b, r_a}) begin
                            r_halt <= 1'b1;
                        end else begin
                            r_a <= 16'd1;
                            r_b <= 16'd0;
                        end
                    end
                    OP_ERR_LEN, OP_ERR_NAME: r_halt <= 1'b1;
                    default: ;
                endcase
            end
        end
    end

    // result payload and check word assembly
    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            if (i_cmd.op == OP_CHK || i_cmd.op == OP_CHK_LAST) r_rcv <= w_rcv;
            case (i_cmd.op)
                OP_NAME: begin
                    r_obyte <= i_cmd.data;
                    r_okind <= KIND_NAME;
                    r_ost   <= ST_OK;
                end
                OP_PAY: begin
                    r_obyte <= i_cmd.data;
                    r_okind <= KIND_PAYLOAD;
                    r_ost   <= ST_OK;
                end
                OP_CHK_LAST: begin
                    r_obyte <= 8'd0;
                    r_okind <= KIND_STATUS;
                    r_ost   <= (w_rcv != {r_b, r_a}) ? ST_BAD_SUM : ST_OK;
                end
                OP_ERR_LEN: begin
                    r_obyte <= 8'd0;
                    r_okind <= KIND_STATUS;
                    r_ost   <= ST_BAD_LEN;
                end
                OP_ERR_NAME: begin
                    r_obyte <= 8'd0;
                    r_okind <= KIND_STATUS;
                    r_ost   <= ST_BAD_NAME;
                end
                default: ;
            endcase
        end
    end

endmodule
